### rtl/core/iic_pkg.sv
package iic_pkg;

    localparam int IIC_TRIG_ITERATIONS = 32;
    localparam int ITER_CAP = 60;

    localparam int VEL_W = 40;
    localparam int RAND_W = 32;
    localparam int FRAC_W = 32;
    localparam int THR_W = 63;
    localparam int CFG_W = 63;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MASS_FRAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 2'd2;

    // relative speed squared and its root
    localparam int RAD_W = 82;
    localparam int VR_W = RAD_W / 2;
    // sine from cosine
    localparam int SQN_W = 64;
    localparam int SX_W = SQN_W / 2;

    // cordic vector and angle
    localparam int XY_W = 43;
    localparam int ZA_W = 64;
    localparam logic signed [XY_W-1:0] CORDIC_K_Q40 = 43'sd667681663043;
    localparam logic [63:0] INV_2PI_Q64 = 64'h28BE60DB9391054A;

    localparam int IN_TDATA_W = 6 * VEL_W + 2 * RAND_W;
    localparam int OUT_TDATA_W = 6 * VEL_W;

    // shift-subtract division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q62 turns
    function automatic logic [63:0] atan_step(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] term;
        logic [127:0] prod;
        int unsigned e;
        if (i == 0)
        begin
            return 64'd1 << 59;
        end
        sum = '0;
        for (int unsigned k = 0; k < 32; k++)
        begin
            e = i * (2 * k + 1);
            if (e <= 62)
            begin
                term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
                if (k[0])
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
        end
        prod = {64'd0, sum} * {64'd0, INV_2PI_Q64};
        return prod[127:64];
    endfunction

endpackage

### rtl/core/iic_isqrt.sv
module iic_isqrt #(
    parameter int IN_W = iic_pkg::RAD_W
) (
    input  logic                clk,
    input  logic                en,
    input  logic [IN_W-1:0]     rad,
    output logic [IN_W/2-1:0]   root
);

    localparam int OUT_W = IN_W / 2;

    logic [IN_W-1:0]  rem_reg  [OUT_W-1];
    logic [OUT_W-1:0] root_reg [OUT_W];

    genvar j;
    for (j = 0; j < OUT_W; j++)
    begin : g_step
        localparam int B = OUT_W - 1 - j;
        logic [IN_W-1:0]  rem_in;
        logic [IN_W-1:0]  trial;
        logic [OUT_W-1:0] root_in;
        logic             take;

        if (j == 0)
        begin : g_first
            assign rem_in  = rad;
            assign root_in = '0;
        end
        else
        begin : g_later
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        // (r + 2^b)^2 - r^2
        assign trial = (IN_W'(root_in) << (B + 1)) | (IN_W'(1) << (2 * B));
        assign take  = rem_in >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[j] <= take ? (root_in | (OUT_W'(1) << B)) : root_in;
            end
        end

        if (j < OUT_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= take ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign root = root_reg[OUT_W-1];

endmodule

### rtl/core/iic_cordic.sv
module iic_cordic #(
    parameter int ITER = iic_pkg::IIC_TRIG_ITERATIONS
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [iic_pkg::RAND_W-1:0]          turns,
    output logic signed [iic_pkg::XY_W-1:0]     co,
    output logic signed [iic_pkg::XY_W-1:0]     si
);

    localparam int XW = iic_pkg::XY_W;
    localparam int ZW = iic_pkg::ZA_W;

    logic [32:0] qsum;
    logic [1:0]  quad_next;
    logic [31:0] resid;

    logic signed [XW-1:0] x_reg [ITER+1];
    logic signed [XW-1:0] y_reg [ITER+1];
    logic signed [ZW-1:0] z_reg [ITER+1];
    logic [1:0]           q_reg [ITER+1];

    // quadrant from the rounded top two bits
    assign qsum      = {1'b0, turns} + 33'(32'd1 << 29);
    assign quad_next = qsum[31:30];
    assign resid     = turns - {quad_next, 30'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= iic_pkg::CORDIC_K_Q40;
            y_reg[0] <= '0;
            z_reg[0] <= $signed({{2{resid[31]}}, resid, 30'd0});
            q_reg[0] <= quad_next;
        end
    end

    genvar j;
    for (j = 0; j < ITER; j++)
    begin : g_rot
        localparam logic signed [ZW-1:0] ANG = $signed(iic_pkg::atan_step(j));
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;

        assign xs = x_reg[j] >>> j;
        assign ys = y_reg[j] >>> j;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j+1] <= q_reg[j];
                if (!z_reg[j][ZW-1])
                begin
                    x_reg[j+1] <= x_reg[j] - ys;
                    y_reg[j+1] <= y_reg[j] + xs;
                    z_reg[j+1] <= z_reg[j] - ANG;
                end
                else
                begin
                    x_reg[j+1] <= x_reg[j] + ys;
                    y_reg[j+1] <= y_reg[j] - xs;
                    z_reg[j+1] <= z_reg[j] + ANG;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (q_reg[ITER])
                2'd0:
                begin
                    co <= x_reg[ITER];
                    si <= y_reg[ITER];
                end
                2'd1:
                begin
                    co <= -y_reg[ITER];
                    si <= x_reg[ITER];
                end
                2'd2:
                begin
                    co <= -x_reg[ITER];
                    si <= -y_reg[ITER];
                end
                default:
                begin
                    co <= y_reg[ITER];
                    si <= -x_reg[ITER];
                end
            endcase
        end
    end

endmodule

### rtl/core/inelastic_isotropic_collision.sv
// Isotropic inelastic collision of one particle pair per item. The block takes both
// velocities and two random fractions, and returns both velocities after an isotropic
// scatter about the center of mass at speed sqrt(|v1-v2|^2 - threshold_speed_sq).
// It accepts one item per cycle while no result waits in the skid register, and
// delivers results in order. The longest path is the 41-stage square-root pipeline
// of the relative speed (or the cordic chain when TRIG_ITERATIONS is large). A
// two-entry output buffer keeps s_axis_tready high while one result waits. The user
// must write configuration only while no item is in flight; the block itself does
// not enforce this.
module inelastic_isotropic_collision #(
    parameter int TRIG_ITERATIONS = iic_pkg::IIC_TRIG_ITERATIONS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // first_vel_x, first_vel_y, first_vel_z, second_vel_x, second_vel_y,
    // second_vel_z, rand_azimuth, rand_polar
    input  logic [iic_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // new_first_vel_x, new_first_vel_y, new_first_vel_z, new_second_vel_x,
    // new_second_vel_y, new_second_vel_z
    output logic [iic_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // below_threshold
    output logic [0:0]                          m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [iic_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [iic_pkg::CFG_W-1:0]           cfg_data
);

    localparam int VW = iic_pkg::VEL_W;
    localparam int RW = iic_pkg::RAND_W;
    localparam int FW = iic_pkg::FRAC_W;
    localparam int XW = iic_pkg::XY_W;
    localparam int RADW = iic_pkg::RAD_W;
    localparam int VRW = iic_pkg::VR_W;
    localparam int SXW = iic_pkg::SX_W;
    localparam int WW = 43;
    localparam int UW = 33;
    localparam int PW = 43;
    localparam int NW = 44;

    localparam int N_ITER = (TRIG_ITERATIONS < iic_pkg::ITER_CAP) ?
                            TRIG_ITERATIONS : iic_pkg::ITER_CAP;
    localparam int ST_RAD = 5;
    localparam int ST_VR = ST_RAD + VRW;
    localparam int ST_S = ST_VR + 2;
    localparam int ST_TRIG = N_ITER + 2;
    localparam int ST_SX = 1 + SXW;
    localparam int ST_DIR = ((ST_TRIG > ST_SX) ? ST_TRIG : ST_SX) + 1;
    localparam int ST_U = ST_DIR + 2;
    localparam int ST_JOIN = ((ST_S > ST_U) ? ST_S : ST_U) + 1;
    localparam int ST_LAST = ST_JOIN + 3;
    localparam int DLY_TRIG = ST_DIR - ST_TRIG;
    localparam int DLY_SX = ST_DIR - ST_SX;
    localparam int DLY_C = ST_U - 1;
    localparam int DLY_S = ST_JOIN - ST_S;
    localparam int DLY_U = ST_JOIN - ST_U;
    localparam int DLY_W = ST_JOIN - ST_RAD;

    typedef struct packed {
        logic                   flag;
        logic [2:0][WW-1:0]     w;
        logic [2:0][VW-1:0]     v2;
    } vel_t;

    typedef struct packed {
        logic [VRW-1:0]         s1;
        logic [VRW-1:0]         s2;
    } spd_t;

    typedef struct packed {
        logic flag;
        logic [2:0][VW-1:0]     n1;
        logic [2:0][VW-1:0]     n2;
    } res_t;

    function automatic logic [VW-1:0] sat40(input logic signed [NW-1:0] v);
        if (v > 44'sd549755813887)
        begin
            return {1'b0, {(VW-1){1'b1}}};
        end
        else if (v < -44'sd549755813888)
        begin
            return {1'b1, {(VW-1){1'b0}}};
        end
        return v[VW-1:0];
    endfunction

    logic en;
    logic [ST_LAST:0] vld_reg;

    // configuration
    logic [FW-1:0]             f2_reg;
    logic [iic_pkg::THR_W-1:0] thr_reg;
    logic                      hold_reg;
    logic [FW:0]               f1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_reg   <= 32'h8000_0000;
            thr_reg  <= '0;
            hold_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                iic_pkg::CFG_MASS_FRAC: f2_reg <= cfg_data[FW-1:0];
                iic_pkg::CFG_THRESHOLD: thr_reg <= cfg_data[iic_pkg::THR_W-1:0];
                iic_pkg::CFG_HOLD:      hold_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    assign f1 = {1'b1, {FW{1'b0}}} - {1'b0, f2_reg};

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ST_LAST-1:0], s_axis_tvalid};
        end
    end

    // stage 0: input
    logic [2:0][VW-1:0] v1_s0_reg;
    logic [2:0][VW-1:0] v2_s0_reg;
    logic [RW-1:0]      ra_s0_reg;
    logic [RW-1:0]      rp_s0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_s0_reg <= s_axis_tdata[3*VW-1:0];
            v2_s0_reg <= s_axis_tdata[6*VW-1:3*VW];
            ra_s0_reg <= s_axis_tdata[6*VW+RW-1:6*VW];
            rp_s0_reg <= s_axis_tdata[6*VW+2*RW-1:6*VW+RW];
        end
    end

    // stage 1: differences, cosine squared
    logic [2:0][VW:0]   dmag_next;
    logic [2:0]         dneg_next;
    logic [2:0][VW:0]   dmag_s1_reg;
    logic [2:0]         dneg_s1_reg;
    logic [2:0][VW-1:0] v2_s1_reg;
    logic signed [RW-1:0] cos_s0;
    logic signed [2*RW-1:0] cos_sq;
    logic [iic_pkg::SQN_W-1:0] sqn_s1_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [VW:0] d;
            d = $signed({v1_s0_reg[k][VW-1], v1_s0_reg[k]})
              - $signed({v2_s0_reg[k][VW-1], v2_s0_reg[k]});
            dneg_next[k] = d[VW];
            dmag_next[k] = d[VW] ? (VW+1)'(-d) : (VW+1)'(d);
        end
    end

    assign cos_s0 = $signed({~rp_s0_reg[RW-1], rp_s0_reg[RW-2:0]});
    assign cos_sq = cos_s0 * cos_s0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_s1_reg <= dmag_next;
            dneg_s1_reg <= dneg_next;
            v2_s1_reg   <= v2_s0_reg;
            sqn_s1_reg  <= (64'd1 << 62) - 64'(cos_sq);
        end
    end

    // stage 2: partial products
    logic [2:0][33:0]   hh_s2_reg;
    logic [2:0][40:0]   hl_s2_reg;
    logic [2:0][47:0]   ll_s2_reg;
    logic [2:0][48:0]   wh_s2_reg;
    logic [2:0][55:0]   wl_s2_reg;
    logic [2:0][VW:0]   dmag_s2_reg;
    logic [2:0]         dneg_s2_reg;
    logic [2:0][VW-1:0] v2_s2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                hh_s2_reg[k] <= dmag_s1_reg[k][40:24] * dmag_s1_reg[k][40:24];
                hl_s2_reg[k] <= dmag_s1_reg[k][40:24] * dmag_s1_reg[k][23:0];
                ll_s2_reg[k] <= dmag_s1_reg[k][23:0] * dmag_s1_reg[k][23:0];
                wh_s2_reg[k] <= dmag_s1_reg[k][40:24] * f1[FW-1:0];
                wl_s2_reg[k] <= dmag_s1_reg[k][23:0] * f1[FW-1:0];
            end
            dmag_s2_reg <= dmag_s1_reg;
            dneg_s2_reg <= dneg_s1_reg;
            v2_s2_reg   <= v2_s1_reg;
        end
    end

    // stage 3: sum partials
    logic [2:0][RADW-1:0] sq_s3_reg;
    logic [2:0][73:0]     wp_s3_reg;
    logic [2:0]           dneg_s3_reg;
    logic [2:0][VW-1:0]   v2_s3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_s3_reg[k] <= (RADW'(hh_s2_reg[k]) << 48) + (RADW'(hl_s2_reg[k]) << 25)
                              + RADW'(ll_s2_reg[k]);
                wp_s3_reg[k] <= (74'(wh_s2_reg[k]) << 24) + 74'(wl_s2_reg[k])
                              + (f1[FW] ? (74'(dmag_s2_reg[k]) << 32) : 74'd0);
            end
            dneg_s3_reg <= dneg_s2_reg;
            v2_s3_reg   <= v2_s2_reg;
        end
    end

    // stage 4: |v1-v2|^2 and center of mass
    logic [RADW-1:0]      sum_s4_reg;
    logic [2:0][WW-1:0]   w_next;
    logic [2:0][WW-1:0]   w_s4_reg;
    logic [2:0][VW-1:0]   v2_s4_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [WW-1:0] wq;
            logic signed [WW-1:0] v2e;
            wq  = $signed(WW'(wp_s3_reg[k][73:32]));
            v2e = WW'($signed(v2_s3_reg[k]));
            w_next[k] = v2e + (dneg_s3_reg[k] ? -wq : wq);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_s4_reg <= sq_s3_reg[0] + sq_s3_reg[1] + sq_s3_reg[2];
            w_s4_reg   <= w_next;
            v2_s4_reg  <= v2_s3_reg;
        end
    end

    // stage 5: subtract threshold
    logic            below;
    logic [RADW-1:0] rad_s5_reg;
    vel_t            vel_s5_reg;

    assign below = sum_s4_reg < RADW'(thr_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_s5_reg      <= below ? '0 : (sum_s4_reg - RADW'(thr_reg));
            vel_s5_reg.flag <= below;
            vel_s5_reg.w    <= w_s4_reg;
            vel_s5_reg.v2   <= v2_s4_reg;
        end
    end

    // relative speed
    logic [VRW-1:0] vr;

    iic_isqrt #(
        .IN_W (RADW)
    ) u_speed_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad_s5_reg),
        .root (vr)
    );

    logic [48:0]    p1h_reg;
    logic [55:0]    p1l_reg;
    logic [48:0]    p2h_reg;
    logic [55:0]    p2l_reg;
    logic [VRW-1:0] vr_reg;
    logic [72:0]    p1;
    logic [72:0]    p2;
    spd_t           spd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1h_reg <= vr[40:24] * f2_reg;
            p1l_reg <= vr[23:0] * f2_reg;
            p2h_reg <= vr[40:24] * f1[FW-1:0];
            p2l_reg <= vr[23:0] * f1[FW-1:0];
            vr_reg  <= vr;
        end
    end

    assign p1 = (73'(p1h_reg) << 24) + 73'(p1l_reg);
    assign p2 = (73'(p2h_reg) << 24) + 73'(p2l_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spd_reg.s1 <= p1[72:32];
            spd_reg.s2 <= f1[FW] ? vr_reg : p2[72:32];
        end
    end

    // direction
    logic signed [XW-1:0] ce;
    logic signed [XW-1:0] se;
    logic [SXW-1:0]       sx;

    iic_cordic #(
        .ITER (N_ITER)
    ) u_cordic (
        .clk   (clk),
        .en    (en),
        .turns (ra_s0_reg),
        .co    (ce),
        .si    (se)
    );

    iic_isqrt #(
        .IN_W (iic_pkg::SQN_W)
    ) u_sine_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (sqn_s1_reg),
        .root (sx)
    );

    logic [2*XW-1:0] trig_dl_reg [DLY_TRIG];
    logic [SXW-1:0]  sx_dl_reg   [DLY_SX];
    logic [RW-1:0]   cos_dl_reg  [DLY_C];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_dl_reg[0] <= {ce, se};
            for (int i = 1; i < DLY_TRIG; i++)
            begin
                trig_dl_reg[i] <= trig_dl_reg[i-1];
            end
            sx_dl_reg[0] <= sx;
            for (int i = 1; i < DLY_SX; i++)
            begin
                sx_dl_reg[i] <= sx_dl_reg[i-1];
            end
            cos_dl_reg[0] <= cos_s0;
            for (int i = 1; i < DLY_C; i++)
            begin
                cos_dl_reg[i] <= cos_dl_reg[i-1];
            end
        end
    end

    logic [1:0][50:0] th_reg;
    logic [1:0][55:0] tl_reg;
    logic [1:0]       tneg_reg;
    logic [1:0][XW-1:0] trig_sel;

    assign trig_sel = trig_dl_reg[DLY_TRIG-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                logic [XW-1:0] tmag;
                tmag = trig_sel[k][XW-1] ? -trig_sel[k] : trig_sel[k];
                // index 1 holds cosine, index 0 sine
                th_reg[k]   <= sx_dl_reg[DLY_SX-1] * tmag[42:24];
                tl_reg[k]   <= sx_dl_reg[DLY_SX-1] * tmag[23:0];
                tneg_reg[k] <= trig_sel[k][XW-1];
            end
        end
    end

    logic [2:0][UW-1:0] u_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                logic [74:0] t;
                logic signed [UW-1:0] m;
                t = (75'(th_reg[k]) << 24) + 75'(tl_reg[k]);
                m = $signed(t[72:40]);
                u_reg[2-k] <= tneg_reg[k] ? -m : m;
            end
            u_reg[0] <= UW'($signed(cos_dl_reg[DLY_C-1]));
        end
    end

    // join
    logic [3*UW-1:0]   u_dl_reg   [DLY_U];
    spd_t              spd_dl_reg [DLY_S];
    vel_t              vel_dl_reg [DLY_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_dl_reg[0] <= u_reg;
            for (int i = 1; i < DLY_U; i++)
            begin
                u_dl_reg[i] <= u_dl_reg[i-1];
            end
            spd_dl_reg[0] <= spd_reg;
            for (int i = 1; i < DLY_S; i++)
            begin
                spd_dl_reg[i] <= spd_dl_reg[i-1];
            end
            vel_dl_reg[0] <= vel_s5_reg;
            for (int i = 1; i < DLY_W; i++)
            begin
                vel_dl_reg[i] <= vel_dl_reg[i-1];
            end
        end
    end

    // speed times direction
    logic [2:0][UW-1:0] u_j;
    spd_t               spd_j;
    logic [2:0][48:0]   a1h_reg;
    logic [2:0][55:0]   a1l_reg;
    logic [2:0][48:0]   a2h_reg;
    logic [2:0][55:0]   a2l_reg;
    logic [2:0]         uneg_reg;
    vel_t               vel_f1_reg;

    assign u_j   = u_dl_reg[DLY_U-1];
    assign spd_j = spd_dl_reg[DLY_S-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic [UW-1:0] um;
                um = u_j[k][UW-1] ? -u_j[k] : u_j[k];
                a1h_reg[k]  <= spd_j.s1[40:24] * um[31:0];
                a1l_reg[k]  <= spd_j.s1[23:0] * um[31:0];
                a2h_reg[k]  <= spd_j.s2[40:24] * um[31:0];
                a2l_reg[k]  <= spd_j.s2[23:0] * um[31:0];
                uneg_reg[k] <= u_j[k][UW-1];
            end
            vel_f1_reg <= vel_dl_reg[DLY_W-1];
        end
    end

    logic [2:0][PW-1:0] q1_reg;
    logic [2:0][PW-1:0] q2_reg;
    vel_t               vel_f2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic [72:0] t1;
                logic [72:0] t2;
                logic signed [PW-1:0] m1;
                logic signed [PW-1:0] m2;
                t1 = (73'(a1h_reg[k]) << 24) + 73'(a1l_reg[k]);
                t2 = (73'(a2h_reg[k]) << 24) + 73'(a2l_reg[k]);
                m1 = $signed(PW'(t1[72:31]));
                m2 = $signed(PW'(t2[72:31]));
                q1_reg[k] <= uneg_reg[k] ? -m1 : m1;
                q2_reg[k] <= uneg_reg[k] ? -m2 : m2;
            end
            vel_f2_reg <= vel_f1_reg;
        end
    end

    // final velocities
    res_t res_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [NW-1:0] we;
                logic signed [NW-1:0] n1;
                logic signed [NW-1:0] n2;
                we = NW'($signed(vel_f2_reg.w[k]));
                n1 = we + NW'($signed(q1_reg[k]));
                n2 = we - NW'($signed(q2_reg[k]));
                res_reg.n1[k] <= sat40(n1);
                res_reg.n2[k] <= hold_reg ? vel_f2_reg.v2[k] : sat40(n2);
            end
            res_reg.flag <= vel_f2_reg.flag;
        end
    end

    // output register and skid
    logic out_vld_reg;
    logic skid_vld_reg;
    res_t out_reg;
    res_t skid_reg;
    logic arrive;
    logic take;

    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;
    assign arrive        = en && vld_reg[ST_LAST];
    assign take          = out_vld_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (!out_vld_reg || take)
            begin
                out_vld_reg  <= skid_vld_reg || arrive;
                skid_vld_reg <= 1'b0;
            end
            else if (arrive)
            begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || take)
        begin
            out_reg <= skid_vld_reg ? skid_reg : res_reg;
        end
        else if (arrive)
        begin
            skid_reg <= res_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_reg.n2, out_reg.n1};
    assign m_axis_tuser  = out_reg.flag;

endmodule
